// File: design/bmi_pkg.sv
// Shared types, constants and helpers for the bilinear map interpolator.
// Used by every module of the block but bmi_ram; depends on nothing.
package bmi_pkg;

    localparam int MAX_X_POINTS = 16;
    localparam int MAX_Y_POINTS = 16;
    localparam int DATA_WIDTH   = 16;
    localparam int FRAC_BITS    = 16;

    localparam int Q_W        = 16;
    localparam int CI_W       = $clog2(MAX_X_POINTS);
    localparam int RI_W       = $clog2(MAX_Y_POINTS);
    localparam int AI_W       = (CI_W > RI_W) ? CI_W : RI_W;
    localparam int CNT_W      = 5;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GRID_AW    = CI_W + RI_W;
    localparam int DCNT_W     = $clog2(FRAC_BITS + 1);
    localparam int PROD_W     = (DATA_WIDTH + 1) + (FRAC_W + 1);
    localparam int IN_W       = 56;
    localparam int OUT_W      = 64;
    localparam int CFG_IDX_W  = 4;

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Input mode codes
    typedef enum logic [2:0] {
        MODE_SAMPLE  = 3'd0,
        MODE_WR_X    = 3'd1,
        MODE_WR_Y    = 3'd2,
        MODE_WR_GRID = 3'd3,
        MODE_READ    = 3'd4
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_COUNT = 4'd0,
        REG_Y_COUNT = 4'd1
    } reg_idx_t;

    // Command kinds after classification
    typedef enum logic [2:0] {
        CMD_SAMPLE,
        CMD_WR_X,
        CMD_WR_Y,
        CMD_WR_GRID,
        CMD_READ,
        CMD_ZERO,
        CMD_DROP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                     kind;
        logic signed [Q_W-1:0]         x_query;
        logic signed [Q_W-1:0]         y_query;
        logic [CI_W-1:0]               col;
        logic [RI_W-1:0]               row;
        logic signed [DATA_WIDTH-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  result_value;
        logic [CI_W-1:0]               col_low;
        logic [RI_W-1:0]               row_low;
        logic [FRAC_W-1:0]             frac_x;
        logic [FRAC_W-1:0]             frac_y;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EDGE,
        ST_DIV,
        ST_FETCH,
        ST_MUL,
        ST_ADD,
        ST_READ,
        ST_OUT
    } back_state_t;

    // Count register above the maximum acts as the maximum
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                     input logic [CNT_W-1:0] lim);
        return (c > lim) ? lim : c;
    endfunction

endpackage

// File: design/bmi_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bmi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/bmi_front.sv
// Front end: unpacks input transfers and classifies them against the counts.
// Depends on bmi_pkg.
module bmi_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [2:0]                   s_tuser,
    input  logic [bmi_pkg::IN_W-1:0]     s_tdata,
    input  logic [bmi_pkg::CNT_W-1:0]    nx,
    input  logic [bmi_pkg::CNT_W-1:0]    ny,
    input  logic                         q_full,
    output logic                         q_push,
    output bmi_pkg::cmd_t                q_data
);
    import bmi_pkg::*;

    logic [2:0]      mode;
    logic            col_ok;
    logic            row_ok;
    cmd_kind_t       kind;

    // Field unpack, first field in the lowest bits
    assign mode            = s_tuser;
    assign q_data.x_query  = s_tdata[15:0];
    assign q_data.y_query  = s_tdata[31:16];
    assign q_data.col      = s_tdata[35:32];
    assign q_data.row      = s_tdata[39:36];
    assign q_data.value    = s_tdata[55:40];

    assign col_ok = {1'b0, q_data.col} < nx;
    assign row_ok = {1'b0, q_data.row} < ny;

    // Classify; out-of-range writes and unused modes are dropped here
    always_comb
    begin
        case (mode)
            MODE_SAMPLE:  kind = (nx == '0 || ny == '0) ? CMD_ZERO : CMD_SAMPLE;
            MODE_WR_X:    kind = col_ok ? CMD_WR_X : CMD_DROP;
            MODE_WR_Y:    kind = row_ok ? CMD_WR_Y : CMD_DROP;
            MODE_WR_GRID: kind = (col_ok && row_ok) ? CMD_WR_GRID : CMD_DROP;
            MODE_READ:    kind = (col_ok && row_ok) ? CMD_READ : CMD_ZERO;
            default:      kind = CMD_DROP;
        endcase
    end

    assign q_data.kind = kind;
    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full && (kind != CMD_DROP);

endmodule

// File: design/bmi_queue.sv
// Two-entry command queue between front and back end.
// Depends on bmi_pkg.
module bmi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bmi_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output bmi_pkg::cmd_t pop_data
);
    import bmi_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/bmi_back.sv
// Back end: breakpoint and grid storage, cell search, fraction divider,
// corner fetch and blend, and the output register. Depends on bmi_pkg, bmi_ram.
module bmi_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  bmi_pkg::cmd_t             q_data,
    output logic                      q_pop,
    input  logic [bmi_pkg::CNT_W-1:0] nx,
    input  logic [bmi_pkg::CNT_W-1:0] ny,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bmi_pkg::result_t          out_data
);
    import bmi_pkg::*;

    back_state_t                   state_reg, state_next;
    cmd_t                          cmd_reg, cmd_next;
    logic                          axis_reg, axis_next;
    logic [AI_W-1:0]               i_reg, i_next;
    logic signed [Q_W-1:0]         prev_reg, prev_next;
    logic [CI_W-1:0]               cl_reg, cl_next;
    logic [RI_W-1:0]               rl_reg, rl_next;
    logic [FRAC_W-1:0]             fx_reg, fx_next;
    logic [FRAC_W-1:0]             fy_reg, fy_next;
    logic [Q_W:0]                  span_reg, span_next;
    logic [Q_W+1:0]                rem_reg, rem_next;
    logic [FRAC_W-1:0]             quo_reg, quo_next;
    logic [DCNT_W-1:0]             dcnt_reg, dcnt_next;
    logic [2:0]                    k_reg, k_next;
    logic signed [DATA_WIDTH-1:0]  v_reg [4];
    logic signed [DATA_WIDTH-1:0]  v_next [4];
    logic [1:0]                    lsel_reg, lsel_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [DATA_WIDTH-1:0]  top_reg, top_next;
    logic signed [DATA_WIDTH-1:0]  bot_reg, bot_next;
    result_t                       pend_reg, pend_next;
    result_t                       out_data_reg, out_data_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0]  x_pts_reg [MAX_X_POINTS];
    logic signed [DATA_WIDTH-1:0]  y_pts_reg [MAX_Y_POINTS];
    logic [GRID_DEPTH-1:0]         gvalid_reg;
    logic                          rvld_reg;

    logic                          ram_we;
    logic [GRID_AW-1:0]            ram_addr;
    logic [DATA_WIDTH-1:0]         ram_rdata;
    logic signed [DATA_WIDTH-1:0]  grid_rd;

    // Axis-dependent views
    logic [CNT_W-1:0]              n_cur;
    logic signed [Q_W-1:0]         q_cur;
    logic [AI_W-1:0]               rd_idx;
    logic signed [DATA_WIDTH-1:0]  bp;
    logic signed [Q_W:0]           span_w;
    logic signed [Q_W:0]           num_w;
    logic [Q_W+1:0]                r2;
    logic                          ge;
    logic [FRAC_W-1:0]             quo_step;
    logic [CNT_W-1:0]              ch_w, rh_w;
    logic [CI_W-1:0]               ch;
    logic [RI_W-1:0]               rh;
    logic signed [DATA_WIDTH-1:0]  la, lb;
    logic [FRAC_W-1:0]             lf;
    logic signed [DATA_WIDTH:0]    ldiff;
    logic signed [DATA_WIDTH-1:0]  lsum;
    logic                          axis_done;
    logic [AI_W-1:0]               low_v;
    logic [FRAC_W-1:0]             frac_v;
    logic                          out_load;

    assign n_cur  = axis_reg ? ny : nx;
    assign q_cur  = axis_reg ? cmd_reg.y_query : cmd_reg.x_query;
    assign rd_idx = (state_reg == ST_EDGE) ? AI_W'(n_cur - CNT_W'(1)) : i_reg;
    assign bp     = axis_reg ? y_pts_reg[RI_W'(rd_idx)] : x_pts_reg[CI_W'(rd_idx)];
    assign span_w = (Q_W+1)'(bp) - (Q_W+1)'(prev_reg);
    assign num_w  = (Q_W+1)'(q_cur) - (Q_W+1)'(prev_reg);

    // One restoring division step per cycle
    assign r2       = {rem_reg[Q_W:0], 1'b0};
    assign ge       = r2 >= {1'b0, span_reg};
    assign quo_step = {quo_reg[FRAC_W-2:0], ge};

    // Upper corner indices, held at the last point
    assign ch_w = ({1'b0, cl_reg} + CNT_W'(1) < nx) ? {1'b0, cl_reg} + CNT_W'(1)
                                                    : nx - CNT_W'(1);
    assign rh_w = ({1'b0, rl_reg} + CNT_W'(1) < ny) ? {1'b0, rl_reg} + CNT_W'(1)
                                                    : ny - CNT_W'(1);
    assign ch   = CI_W'(ch_w);
    assign rh   = RI_W'(rh_w);

    // Blend operand selection
    always_comb
    begin
        case (lsel_reg)
            2'd0:    begin la = v_reg[0]; lb = v_reg[1]; lf = fx_reg; end
            2'd1:    begin la = v_reg[2]; lb = v_reg[3]; lf = fx_reg; end
            default: begin la = top_reg;  lb = bot_reg;  lf = fy_reg; end
        endcase
    end
    assign ldiff = (DATA_WIDTH+1)'(lb) - (DATA_WIDTH+1)'(la);
    assign lsum  = la + DATA_WIDTH'(prod_reg >>> FRAC_BITS);

    assign grid_rd  = rvld_reg ? $signed(ram_rdata) : '0;
    assign out_load = !out_valid_reg || out_ready;

    // Grid RAM address
    always_comb
    begin
        if (state_reg == ST_FETCH)
        begin
            case (k_reg)
                3'd0:    ram_addr = {rl_reg, cl_reg};
                3'd1:    ram_addr = {rl_reg, ch};
                3'd2:    ram_addr = {rh, cl_reg};
                default: ram_addr = {rh, ch};
            endcase
        end
        else
        begin
            ram_addr = {q_data.row, q_data.col};
        end
    end

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign ram_we = q_pop && (q_data.kind == CMD_WR_GRID);

    bmi_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_data.value),
        .rdata (ram_rdata)
    );

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        axis_next      = axis_reg;
        i_next         = i_reg;
        prev_next      = prev_reg;
        cl_next        = cl_reg;
        rl_next        = rl_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        lsel_next      = lsel_reg;
        prod_next      = prod_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        pend_next      = pend_reg;
        axis_done      = 1'b0;
        low_v          = '0;
        frac_v         = '0;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_data;
                    case (q_data.kind)
                        CMD_SAMPLE:
                        begin
                            axis_next  = 1'b0;
                            i_next     = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_READ:
                        begin
                            state_next = ST_READ;
                        end
                        CMD_ZERO:
                        begin
                            pend_next  = '0;
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Linear scan over breakpoints, one per cycle
            ST_SCAN:
            begin
                if (i_reg == '0)
                begin
                    if (n_cur == CNT_W'(1) || q_cur <= bp)
                    begin
                        axis_done = 1'b1;
                    end
                    else
                    begin
                        prev_next  = bp;
                        state_next = ST_EDGE;
                    end
                end
                else if (bp > q_cur)
                begin
                    low_v = i_reg - AI_W'(1);
                    if (!span_w[Q_W] && span_w != '0)
                    begin
                        span_next  = span_w;
                        rem_next   = {1'b0, num_w};
                        quo_next   = '0;
                        dcnt_next  = DCNT_W'(FRAC_BITS);
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        axis_done = 1'b1;
                    end
                end
                else
                begin
                    prev_next = bp;
                    i_next    = i_reg + AI_W'(1);
                end
            end

            // Check against the last breakpoint
            ST_EDGE:
            begin
                if (q_cur >= bp)
                begin
                    axis_done = 1'b1;
                    low_v     = AI_W'(n_cur - CNT_W'(2));
                    frac_v    = FRAC_ONE;
                end
                else
                begin
                    i_next     = AI_W'(1);
                    state_next = ST_SCAN;
                end
            end

            ST_DIV:
            begin
                rem_next  = ge ? (r2 - {1'b0, span_reg}) : r2;
                quo_next  = quo_step;
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                begin
                    axis_done = 1'b1;
                    low_v     = i_reg - AI_W'(1);
                    frac_v    = quo_step;
                end
            end

            // Four corner reads, data arriving the cycle after its address
            ST_FETCH:
            begin
                if (k_reg != 3'd0)
                begin
                    v_next[2'(k_reg - 3'd1)] = grid_rd;
                end
                if (k_reg == 3'd4)
                begin
                    lsel_next  = 2'd0;
                    state_next = ST_MUL;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end

            ST_MUL:
            begin
                prod_next  = PROD_W'(ldiff) * $signed({1'b0, lf});
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                case (lsel_reg)
                    2'd0:
                    begin
                        top_next   = lsum;
                        lsel_next  = 2'd1;
                        state_next = ST_MUL;
                    end
                    2'd1:
                    begin
                        bot_next   = lsum;
                        lsel_next  = 2'd2;
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        pend_next.result_value = lsum;
                        pend_next.col_low      = cl_reg;
                        pend_next.row_low      = rl_reg;
                        pend_next.frac_x       = fx_reg;
                        pend_next.frac_y       = fy_reg;
                        state_next             = ST_OUT;
                    end
                endcase
            end

            ST_READ:
            begin
                pend_next              = '0;
                pend_next.result_value = grid_rd;
                state_next             = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand-off between the two axes
        if (axis_done)
        begin
            if (!axis_reg)
            begin
                cl_next    = CI_W'(low_v);
                fx_next    = frac_v;
                axis_next  = 1'b1;
                i_next     = '0;
                state_next = ST_SCAN;
            end
            else
            begin
                rl_next    = RI_W'(low_v);
                fy_next    = frac_v;
                k_next     = 3'd0;
                state_next = ST_FETCH;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gvalid_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                gvalid_reg[ram_addr] <= 1'b1;
            end
        end
    end

    // Breakpoint registers, zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_X_POINTS; j++)
            begin
                x_pts_reg[j] <= '0;
            end
            for (int j = 0; j < MAX_Y_POINTS; j++)
            begin
                y_pts_reg[j] <= '0;
            end
        end
        else if (q_pop)
        begin
            if (q_data.kind == CMD_WR_X)
            begin
                x_pts_reg[q_data.col] <= q_data.value;
            end
            if (q_data.kind == CMD_WR_Y)
            begin
                y_pts_reg[q_data.row] <= q_data.value;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        axis_reg     <= axis_next;
        i_reg        <= i_next;
        prev_reg     <= prev_next;
        cl_reg       <= cl_next;
        rl_reg       <= rl_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        span_reg     <= span_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        k_reg        <= k_next;
        v_reg        <= v_next;
        lsel_reg     <= lsel_next;
        prod_reg     <= prod_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
        rvld_reg     <= gvalid_reg[ram_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // Divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < {1'b0, span_reg})
        else $error("divider remainder out of range");

    // Corner fetch starts inside the populated grid
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH && k_reg == 3'd0) |->
            ({1'b0, cl_reg} < nx && {1'b0, rl_reg} < ny))
        else $error("cell index beyond count");

    // A pending result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("result overwritten while stalled");

    // Fractions never exceed one
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.frac_x <= FRAC_ONE && out_data_reg.frac_y <= FRAC_ONE))
        else $error("fraction above one");
`endif

endmodule

// File: design/bilinear_map_interpolator.sv
// Top level of the bilinear map interpolator: configuration registers,
// front end, command queue and back end. Depends on bmi_pkg and all bmi_* modules.
//
//  channel  | direction | handshake             | payload
//  s_axis   | in        | s_axis_tvalid/tready  | tuser mode; x_query, y_query, col, row, value
//  m_axis   | out       | m_axis_tvalid/tready  | result, col_low, row_low, frac_x, frac_y
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data (count registers)
//
// A write ends when it is popped in ST_IDLE; a grid read passes ST_READ and ST_OUT,
// an empty-axis sample goes straight to ST_OUT. A sample is popped, then per axis
// scanned and, for an interior query, divided, then runs corner fetch, blend and output.
// The linear scan and the bit-per-cycle divider set how long a sample takes.
// Reset clears counts, breakpoints and grid valid bits at once; no clearing pass.
// The two-entry queue lets input transfers continue while the output register stalls, until it is full.
module bilinear_map_interpolator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [2:0] mode
    input  logic [2:0]                   s_axis_tuser,
    // [15:0] x_query, [31:16] y_query, [35:32] col_index,
    // [39:36] row_index, [55:40] write_value
    input  logic [bmi_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] result_value, [19:16] col_low, [23:20] row_low,
    // [40:24] frac_x, [57:41] frac_y, [63:58] zero
    output logic [bmi_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bmi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmi_pkg::CNT_W-1:0]    cfg_data
);
    import bmi_pkg::*;

    logic [CNT_W-1:0] x_count_reg, x_count_next;
    logic [CNT_W-1:0] y_count_reg, y_count_next;
    logic [CNT_W-1:0] nx, ny;
    logic             q_full, q_push, q_pop, q_valid;
    cmd_t             push_data, pop_data;
    result_t          res;

    // Count registers
    assign cfg_ready = 1'b1;
    always_comb
    begin
        x_count_next = x_count_reg;
        y_count_next = y_count_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_COUNT: x_count_next = cfg_data;
                REG_Y_COUNT: y_count_next = cfg_data;
                default:     x_count_next = x_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg <= '0;
            y_count_reg <= '0;
        end
        else
        begin
            x_count_reg <= x_count_next;
            y_count_reg <= y_count_next;
        end
    end

    assign nx = clamp_count(x_count_reg, CNT_W'(MAX_X_POINTS));
    assign ny = clamp_count(y_count_reg, CNT_W'(MAX_Y_POINTS));

    bmi_front u_front (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tuser  (s_axis_tuser),
        .s_tdata  (s_axis_tdata),
        .nx       (nx),
        .ny       (ny),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    bmi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_data)
    );

    bmi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .nx        (nx),
        .ny        (ny),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // Result packing, first field lowest
    assign m_axis_tdata = {6'd0, res.frac_y, res.frac_x, res.row_low, res.col_low,
                           res.result_value};

endmodule

// File: verif/tb_bilinear_map_interpolator.sv
// Self-checking bench for bilinear_map_interpolator: programs breakpoints and grid,
// samples and reads, and checks each result against a behavioral model of the map or a typed-in answer.
// Depends on bmi_pkg and the design files.
module tb_bilinear_map_interpolator;

    timeunit 1ns;
    timeprecision 1ps;

    import bmi_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        mode_t              mode;
        logic signed [15:0] xq;
        logic signed [15:0] yq;
        logic [3:0]         col;
        logic [3:0]         row;
        logic signed [15:0] wval;
    } map_cmd_t;

    typedef struct {
        logic signed [15:0] value;
        logic [3:0]         col_low;
        logic [3:0]         row_low;
        logic [16:0]        frac_x;
        logic [16:0]        frac_y;
    } map_ans_t;

    // Directed row: command plus an optional typed-in answer
    typedef struct {
        map_cmd_t cmd;
        bit       fixed;
        map_ans_t ans;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [4:0]  cfg_data;

    // Shadow state of the map
    logic [4:0]         nx_reg, ny_reg;
    logic signed [15:0] xbp   [16];
    logic signed [15:0] ybp   [16];
    logic signed [15:0] cells [256];

    map_ans_t pending_answers[$];
    int       error_count;
    int       cycle_count;
    int       sent_count;
    int       got_count;
    bit       long_hold;

    bilinear_map_interpolator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        error_count++;
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, got_count);
    endtask

    function automatic int unsigned eff(input logic [4:0] c);
        return (c > 5'd16) ? 16 : int'(c);
    endfunction

    function automatic longint floor_q16(input longint p);
        return p >>> 16;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + floor_q16((b - a) * f);
    endfunction

    // Upper-bound cell search along one axis
    function automatic void locate(input logic signed [15:0] bp[16], input int unsigned n,
                                   input longint q, output int unsigned low,
                                   output longint frac);
        int unsigned hi;
        longint span;
        low = 0;
        frac = 0;
        if (n <= 1 || q <= bp[0])
            return;
        if (q >= bp[n-1])
        begin
            low = n - 2;
            frac = 65536;
            return;
        end
        hi = n - 1;
        for (int i = 1; i < n; i++)
        begin
            if (bp[i] > q)
            begin
                hi = i;
                break;
            end
        end
        low = hi - 1;
        span = longint'(bp[hi]) - longint'(bp[hi-1]);
        if (span > 0)
            frac = ((q - longint'(bp[hi-1])) * 65536) / span;
    endfunction

    // Applies one command to the shadow map; returns 1 if it produces an answer
    function automatic bit apply_map(input map_cmd_t c, output map_ans_t a);
        int unsigned nx, ny, cl, rl, ch, rh;
        longint fx, fy, top, bot, res;
        nx = eff(nx_reg);
        ny = eff(ny_reg);
        a = '{default: '0};
        case (c.mode)
            MODE_WR_X:
            begin
                if (c.col < nx) xbp[c.col] = c.wval;
                return 0;
            end
            MODE_WR_Y:
            begin
                if (c.row < ny) ybp[c.row] = c.wval;
                return 0;
            end
            MODE_WR_GRID:
            begin
                if (c.row < ny && c.col < nx) cells[{c.row, c.col}] = c.wval;
                return 0;
            end
            MODE_READ:
            begin
                if (c.row < ny && c.col < nx) a.value = cells[{c.row, c.col}];
                return 1;
            end
            MODE_SAMPLE:
            begin
                if (nx != 0 && ny != 0)
                begin
                    locate(xbp, nx, longint'(c.xq), cl, fx);
                    locate(ybp, ny, longint'(c.yq), rl, fy);
                    ch = (cl + 1 < nx) ? cl + 1 : nx - 1;
                    rh = (rl + 1 < ny) ? rl + 1 : ny - 1;
                    top = blend(cells[rl*16+cl], cells[rl*16+ch], fx);
                    bot = blend(cells[rh*16+cl], cells[rh*16+ch], fx);
                    res = blend(top, bot, fy);
                    a.value = res[15:0];
                    a.col_low = cl[3:0];
                    a.row_low = rl[3:0];
                    a.frac_x = fx[16:0];
                    a.frac_y = fy[16:0];
                end
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic map_cmd_t mk(input mode_t m, input int xq, input int yq,
                                    input int col, input int row, input int wv);
        map_cmd_t c;
        c.mode = m;
        c.xq = xq[15:0];
        c.yq = yq[15:0];
        c.col = col[3:0];
        c.row = row[3:0];
        c.wval = wv[15:0];
        return c;
    endfunction

    function automatic map_cmd_t rand_cmd();
        map_cmd_t c;
        c.mode = mode_t'(3'($urandom_range(0, 4)));
        c.xq = 16'($urandom);
        c.yq = 16'($urandom);
        c.col = 4'($urandom);
        c.row = 4'($urandom);
        c.wval = 16'($urandom);
        return c;
    endfunction

    // Idle gap: mostly short, sometimes long
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        repeat (n) @(negedge clk);
    endtask

    // Drives one transfer on the input stream and queues its expected answer
    task automatic push_cmd(input map_cmd_t c, input bit fixed, input map_ans_t want,
                            input bit gaps);
        map_ans_t a;
        if (gaps) random_gap();
        s_axis_tuser  = c.mode;
        s_axis_tdata  = {c.wval, c.row, c.col, c.yq, c.xq};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (apply_map(c, a))
            pending_answers.push_back(fixed ? want : a);
        sent_count++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_answers.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [4:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_X_COUNT) nx_reg = val; else ny_reg = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Ascending breakpoints, some repeated to give zero spans
    task automatic load_axis(input mode_t m, input int unsigned n, input bit gaps);
        int v;
        map_ans_t none;
        none = '{default: '0};
        v = $urandom_range(0, 1) ? -32768 : int'($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < n; i++)
        begin
            push_cmd(mk(m, 0, 0, i, i, v), 0, none, gaps);
            if ($urandom_range(0, 7) != 0) v += $urandom_range(1, 60000 / (n + 1));
            if (v > 32767) v = 32767;
        end
    endtask

    task automatic load_grid(input int unsigned nx, input int unsigned ny, input bit gaps);
        map_ans_t none;
        none = '{default: '0};
        for (int r = 0; r < ny; r++)
            for (int c = 0; c < nx; c++)
                push_cmd(mk(MODE_WR_GRID, 0, 0, c, r, int'($urandom_range(0, 65535)) - 32768),
                         0, none, gaps);
    endtask

    // Output checker and receiver stalls
    initial
    begin
        map_ans_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
                m_axis_tready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_count++;
                if (pending_answers.size() == 0)
                    report("unexpected result", m_axis_tdata, 64'd0);
                else
                begin
                    want = pending_answers.pop_front();
                    if (m_axis_tdata[15:0] !== want.value)
                        report("result_value", m_axis_tdata[15:0], want.value);
                    if (m_axis_tdata[19:16] !== want.col_low)
                        report("col_low", m_axis_tdata[19:16], want.col_low);
                    if (m_axis_tdata[23:20] !== want.row_low)
                        report("row_low", m_axis_tdata[23:20], want.row_low);
                    if (m_axis_tdata[40:24] !== want.frac_x)
                        report("frac_x", m_axis_tdata[40:24], want.frac_x);
                    if (m_axis_tdata[57:41] !== want.frac_y)
                        report("frac_y", m_axis_tdata[57:41], want.frac_y);
                end
            end
        end
    end

    // Long receiver hold while the sender keeps offering items
    initial
    begin
        long_hold = 1'b0;
        wait (sent_count >= 120);
        @(negedge clk);
        long_hold = 1'b1;
        repeat (600) @(negedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        plan_row_t plan[$];
        map_ans_t zero_ans;
        map_ans_t w;
        int unsigned nx, ny;
        int unsigned sizes[6];

        sizes = '{2, 3, 5, 16, 1, 9};
        zero_ans = '{default: '0};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_COUNT;
        cfg_data = '0;
        error_count = 0;
        sent_count = 0;
        got_count = 0;
        nx_reg = 0;
        ny_reg = 0;
        foreach (xbp[i]) xbp[i] = 0;
        foreach (ybp[i]) ybp[i] = 0;
        foreach (cells[i]) cells[i] = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty axes, ignored writes, then a 16x2 map with extremes
        plan.push_back('{mk(MODE_SAMPLE, 32767, -32768, 0, 0, 0), 1, zero_ans});
        plan.push_back('{mk(MODE_READ, 0, 0, 15, 15, 0), 1, zero_ans});
        plan.push_back('{mk(MODE_WR_GRID, 0, 0, 0, 0, 1234), 0, zero_ans});
        plan.push_back('{mk(MODE_READ, 0, 0, 0, 0, 0), 1, zero_ans});
        foreach (plan[i]) push_cmd(plan[i].cmd, plan[i].fixed, plan[i].ans, 0);
        plan.delete();
        wait_idle();
        write_reg(REG_X_COUNT, 5'd31);
        write_reg(REG_Y_COUNT, 5'd2);
        w = zero_ans;
        w.value = -16'sd32768;
        plan.push_back('{mk(MODE_WR_X, 0, 0, 0, 0, -100), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_X, 0, 0, 1, 0, 100), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_X, 0, 0, 15, 0, 32767), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_Y, 0, 0, 0, 0, -32768), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_Y, 0, 0, 0, 1, 32767), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_Y, 0, 0, 0, 9, 5), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_GRID, 0, 0, 0, 0, -32768), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_GRID, 0, 0, 1, 0, 32767), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_GRID, 0, 0, 0, 1, 32767), 0, zero_ans});
        plan.push_back('{mk(MODE_WR_GRID, 0, 0, 15, 1, -1), 0, zero_ans});
        plan.push_back('{mk(MODE_READ, 0, 0, 0, 0, 0), 1, w});
        plan.push_back('{mk(MODE_READ, 0, 0, 3, 2, 0), 1, zero_ans});
        plan.push_back('{mk(MODE_SAMPLE, -32768, -32768, 0, 0, 0), 1, w});
        plan.push_back('{mk(MODE_SAMPLE, 32767, 32767, 0, 0, 0), 0, zero_ans});
        plan.push_back('{mk(MODE_SAMPLE, 0, 0, 0, 0, 0), 0, zero_ans});
        plan.push_back('{mk(MODE_SAMPLE, 50, -1, 0, 0, 0), 0, zero_ans});
        plan.push_back('{mk(mode_t'(3'd5), 0, 0, 0, 0, 0), 0, zero_ans});
        plan.push_back('{mk(mode_t'(3'd7), -1, -1, 15, 15, -1), 0, zero_ans});
        plan.push_back('{mk(MODE_SAMPLE, 99, 7, 0, 0, 0), 0, zero_ans});
        foreach (plan[i]) push_cmd(plan[i].cmd, plan[i].fixed, plan[i].ans, 0);
        wait_idle();

        // Random phases: program a map, then query it
        for (int ph = 0; ph < 12; ph++)
        begin
            nx = sizes[ph % 6];
            ny = sizes[(ph + 2) % 6];
            write_reg(REG_X_COUNT, (ph == 3) ? 5'd20 : nx[4:0]);
            write_reg(REG_Y_COUNT, ny[4:0]);
            load_axis(MODE_WR_X, nx, ph[0]);
            load_axis(MODE_WR_Y, ny, ph[0]);
            load_grid(nx, ny, ph[0]);
            for (int k = 0; k < 85; k++)
            begin
                map_cmd_t c;
                c = rand_cmd();
                if ($urandom_range(0, 9) < 7)
                begin
                    c.mode = ($urandom_range(0, 4) == 0) ? MODE_READ : MODE_SAMPLE;
                    if ($urandom_range(0, 2) != 0)
                    begin
                        c.xq = xbp[$urandom_range(0, nx - 1)] + $signed(16'($urandom_range(0, 200)));
                        c.yq = ybp[$urandom_range(0, ny - 1)] - $signed(16'($urandom_range(0, 200)));
                    end
                end
                push_cmd(c, 0, zero_ans, 1);
            end
            // Sender pause until every answer has arrived
            wait_idle();
        end
        wait_idle();

        $display("Covered %0d input transfers and %0d checked results over 12 map layouts,",
                 sent_count, got_count);
        $display("including empty axes, clamped counts, unused modes and a long output stall.");
        if (error_count == 0 && pending_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
design/bmi_pkg.sv
design/bmi_ram.sv
design/bmi_front.sv
design/bmi_queue.sv
design/bmi_back.sv
design/bilinear_map_interpolator.sv
verif/tb_bilinear_map_interpolator.sv
